// ----- rtl/acm_pkg.sv -----
// Package: shared types, constants and set selection for the actuator channel mixer.
`default_nettype none
package acm_pkg;

    localparam int CHANNELS     = 8;
    localparam int THROW_SETS   = 4;
    localparam int CAMBER_SETS  = 4;
    localparam int SPECIAL_SETS = 4;
    localparam int CH_LIMIT     = (CHANNELS < 8) ? CHANNELS : 8;

    localparam logic [2:0] CMD_MIX     = 3'd0;
    localparam logic [2:0] CMD_COEF    = 3'd1;
    localparam logic [2:0] CMD_TMIN    = 3'd2;
    localparam logic [2:0] CMD_TMAX    = 3'd3;
    localparam logic [2:0] CMD_TMID    = 3'd4;
    localparam logic [2:0] CMD_CAMBER  = 3'd5;
    localparam logic [2:0] CMD_SPECIAL = 3'd6;

    localparam logic [1:0] REG_ACTIVE  = 2'd0;
    localparam logic [1:0] REG_FLOOR   = 2'd1;
    localparam logic [1:0] REG_CEILING = 2'd2;

    typedef struct packed {
        logic       en;
        logic [1:0] idx;
        logic       fb;
    } pick_t;

    typedef struct packed {
        logic [2:0]         ch;
        logic               last;
        logic               fb;
        logic               t_en;
        logic               c_en;
        logic               s_en;
        logic [3:0][15:0]   cmds;
        logic [15:0]        camt;
        logic [15:0]        samt;
    } meta_t;

    typedef struct packed {
        logic [3:0][15:0] coef;
        logic [15:0]      tl;
        logic [15:0]      th;
        logic [15:0]      tm;
        logic [15:0]      cam;
        logic [15:0]      spc;
    } rd_t;

    typedef struct packed {
        logic [2:0] ch;
        logic       last;
        logic       fb;
    } tag_t;

    function automatic pick_t pick_set(input logic [2:0] sel, input logic [3:0] present,
                                       input int sets);
        pick_t r;
        r.en  = 1'b0;
        r.idx = 2'd0;
        r.fb  = 1'b0;
        if (int'(sel) < sets && present[sel[1:0]]) begin
            r.en  = 1'b1;
            r.idx = sel[1:0];
        end else begin
            r.fb = 1'b1;
            for (int s = 3; s >= 0; s--) begin
                if (s < sets && present[s]) begin
                    r.en  = 1'b1;
                    r.idx = 2'(s);
                end
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/acm_tables.sv -----
// Coefficient, throw and offset table memories with registered reads.
`default_nettype none
module acm_tables
    import acm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_cmd,
    input  wire logic [4:0]  wr_idx,
    input  wire logic [15:0] wr_data,
    input  wire logic        rd_en,
    input  wire logic [2:0]  rd_ch,
    input  wire logic [4:0]  rd_taddr,
    input  wire logic [4:0]  rd_caddr,
    input  wire logic [4:0]  rd_saddr,
    output rd_t              rd_data
);
    logic [3:0][15:0] coef_mem [CHANNELS];
    logic [15:0] tl_mem [32];
    logic [15:0] th_mem [32];
    logic [15:0] tm_mem [32];
    logic [15:0] cam_mem [32];
    logic [15:0] spc_mem [32];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            case (wr_cmd)
                CMD_COEF:    coef_mem[wr_idx[4:2]][wr_idx[1:0]] <= wr_data;
                CMD_TMIN:    tl_mem[wr_idx] <= wr_data;
                CMD_TMAX:    th_mem[wr_idx] <= wr_data;
                CMD_TMID:    tm_mem[wr_idx] <= wr_data;
                CMD_CAMBER:  cam_mem[wr_idx] <= wr_data;
                CMD_SPECIAL: spc_mem[wr_idx] <= wr_data;
                default: ;
            endcase
        end
        if (rd_en) begin
            rd_data.coef <= coef_mem[rd_ch];
            rd_data.tl   <= tl_mem[rd_taddr];
            rd_data.th   <= th_mem[rd_taddr];
            rd_data.tm   <= tm_mem[rd_taddr];
            rd_data.cam  <= cam_mem[rd_caddr];
            rd_data.spc  <= spc_mem[rd_saddr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/acm_dp.sv -----
// Mixing datapath: products, mix sum, throw scaling, offsets, clamp, rounding, output register.
`default_nettype none
module acm_dp
    import acm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    input  wire meta_t       in_meta,
    input  wire rd_t         in_rd,
    input  wire logic [15:0] out_floor,
    input  wire logic [15:0] out_ceiling,
    output logic             adv,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    output logic             m_tuser,
    output logic             m_tlast
);
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    tag_t t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [3:0][31:0] prod_reg;
    logic signed [16:0] dn1_reg, up1_reg, dn2_reg, up2_reg;
    logic [15:0] md1_reg, md2_reg, md3_reg;
    logic signed [31:0] coff_reg, soff_reg;
    logic signed [33:0] mix_reg;
    logic signed [32:0] off2_reg, off3_reg;
    logic signed [50:0] v_reg;
    logic signed [53:0] acc_reg;
    logic [2:0] och_reg;
    logic [15:0] opulse_reg;
    logic ofb_reg, olast_reg;

    logic signed [33:0] mix_next;
    logic signed [16:0] dsel;
    logic signed [50:0] v_next;
    logic signed [53:0] sum, lo, hi, clamped, acc_next, rnd;

    assign adv = !vo_reg || m_tready;

    always_comb begin
        mix_next = 34'($signed(prod_reg[0])) + 34'($signed(prod_reg[1]))
                 + 34'($signed(prod_reg[2])) + 34'($signed(prod_reg[3]));
        dsel     = mix_reg[33] ? dn2_reg : up2_reg;
        v_next   = mix_reg * dsel;
        lo       = $signed({9'b0, out_floor, 29'b0});
        hi       = $signed({9'b0, out_ceiling, 29'b0});
        sum      = $signed({{3{v_reg[50]}}, v_reg}) + $signed({9'b0, md3_reg, 29'b0})
                 + $signed({{7{off3_reg[32]}}, off3_reg, 14'b0});
        acc_next = (sum < lo) ? lo : sum;
        clamped  = (acc_reg > hi) ? hi : acc_reg;
        rnd      = clamped + $signed(54'd268435456);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            vo_reg <= v4_reg;
        end
        if (adv) begin
            t1_reg <= '{ch: in_meta.ch, last: in_meta.last, fb: in_meta.fb};
            for (int a = 0; a < 4; a++) begin
                prod_reg[a] <= $signed(in_rd.coef[a]) * $signed(in_meta.cmds[a]);
            end
            dn1_reg  <= in_meta.t_en ? $signed({1'b0, in_rd.tm}) - $signed({1'b0, in_rd.tl})
                                     : 17'sd0;
            up1_reg  <= in_meta.t_en ? $signed({1'b0, in_rd.th}) - $signed({1'b0, in_rd.tm})
                                     : 17'sd0;
            md1_reg  <= in_meta.t_en ? in_rd.tm : 16'd0;
            coff_reg <= in_meta.c_en ? $signed(in_rd.cam) * $signed(in_meta.camt) : 32'sd0;
            soff_reg <= in_meta.s_en ? $signed(in_rd.spc) * $signed(in_meta.samt) : 32'sd0;

            t2_reg   <= t1_reg;
            mix_reg  <= mix_next;
            off2_reg <= 33'(coff_reg) + 33'(soff_reg);
            dn2_reg  <= dn1_reg;
            up2_reg  <= up1_reg;
            md2_reg  <= md1_reg;

            t3_reg   <= t2_reg;
            v_reg    <= v_next;
            off3_reg <= off2_reg;
            md3_reg  <= md2_reg;

            t4_reg   <= t3_reg;
            acc_reg  <= acc_next;

            och_reg    <= t4_reg.ch;
            ofb_reg    <= t4_reg.fb;
            olast_reg  <= t4_reg.last;
            opulse_reg <= rnd[44:29];
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {5'b0, opulse_reg, och_reg};
    assign m_tuser  = ofb_reg;
    assign m_tlast  = olast_reg;
endmodule
`default_nettype wire

// ----- rtl/actuator_channel_mixer_top.sv -----
// Top level: input sequencer, configuration registers, tables and mixing pipeline.
//
// Input channel s_*: s_tuser carries the command. Write commands load the
// coefficient, throw, camber and special tables and give no transfer out.
// A mix command gives one output transfer per active channel, channels in
// ascending order, m_tlast on the final one, m_tuser = fallback.
// The sequencer issues one channel per cycle, while the pipeline advances,
// into a six-register pipeline (table read, products, mix sum, throw
// scaling, offsets and floor clamp, ceiling clamp and rounding into the
// output register); s_tready is low while a mix item's channels are issued.
// The next item is taken once the last channel is issued; write items are
// taken back to back. The config port (cfg_we, cfg_index, cfg_data) is to
// be written only while idle; the block itself does not enforce this.
// Reset clears the sequencer, pipeline valids, set-present flags and sets
// active_channels 8, floor 1000, ceiling 2000; table contents stay as is.
// When m_tvalid is high and m_tready is low, the whole pipeline and the
// channel issue hold; nothing is lost or repeated.
`default_nettype none
module actuator_channel_mixer_top
    import acm_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // roll, pitch, yaw, throttle, throw_sel, camber_sel, camber_amount,
    // special_sel, special_amount, write_index, write_data, zero pad
    input  wire logic [127:0] s_tdata,
    // cmd
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // channel, pulse_value, zero pad
    output logic [23:0]       m_tdata,
    // fallback
    output logic              m_tuser,
    output logic              m_tlast,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);
    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t      state_reg;
    logic [3:0]  active_reg;
    logic [15:0] floor_reg, ceiling_reg;
    logic [3:0]  tpres_reg, cpres_reg, spres_reg;
    logic [2:0]  ch_reg;
    logic [3:0]  n_reg;
    meta_t       item_reg;
    logic [1:0]  tidx_reg, cidx_reg, sidx_reg;
    logic        v0_reg;
    meta_t       meta_reg;

    logic        adv, acc, issue;
    logic [2:0]  cmd, csel, ssel;
    logic [4:0]  widx;
    logic [15:0] wdata;
    logic        wr_ok;
    pick_t       tp, cp, sp;
    logic [3:0]  n_next;
    meta_t       meta_next;
    rd_t         rd_data;

    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign issue    = (state_reg == ST_RUN) && adv;
    assign cmd      = s_tuser;
    assign csel     = s_tdata[68:66];
    assign ssel     = s_tdata[87:85];
    assign widx     = s_tdata[108:104];
    assign wdata    = s_tdata[124:109];

    always_comb begin
        tp = pick_set({1'b0, s_tdata[65:64]}, tpres_reg, THROW_SETS);
        cp = pick_set(csel - 3'd1, cpres_reg, CAMBER_SETS);
        sp = pick_set(ssel - 3'd1, spres_reg, SPECIAL_SETS);
        n_next = (int'(active_reg) > CH_LIMIT) ? 4'(CH_LIMIT) : active_reg;
        meta_next      = item_reg;
        meta_next.ch   = ch_reg;
        meta_next.last = ({1'b0, ch_reg} + 4'd1 == n_reg);
        case (cmd)
            CMD_COEF:
                wr_ok = int'(widx[4:2]) < CH_LIMIT;
            CMD_TMIN, CMD_TMAX, CMD_TMID:
                wr_ok = int'(widx[4:3]) < THROW_SETS && int'(widx[2:0]) < CH_LIMIT;
            CMD_CAMBER:
                wr_ok = int'(widx[4:3]) < CAMBER_SETS && int'(widx[2:0]) < CH_LIMIT;
            CMD_SPECIAL:
                wr_ok = int'(widx[4:3]) < SPECIAL_SETS && int'(widx[2:0]) < CH_LIMIT;
            default:
                wr_ok = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            active_reg  <= 4'd8;
            floor_reg   <= 16'd1000;
            ceiling_reg <= 16'd2000;
            tpres_reg   <= '0;
            cpres_reg   <= '0;
            spres_reg   <= '0;
            ch_reg      <= '0;
            n_reg       <= '0;
            v0_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ACTIVE:  active_reg  <= cfg_data[3:0];
                    REG_FLOOR:   floor_reg   <= cfg_data;
                    REG_CEILING: ceiling_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (acc && wr_ok) begin
                case (cmd)
                    CMD_TMIN, CMD_TMAX, CMD_TMID: tpres_reg[widx[4:3]] <= 1'b1;
                    CMD_CAMBER:  cpres_reg[widx[4:3]] <= 1'b1;
                    CMD_SPECIAL: spres_reg[widx[4:3]] <= 1'b1;
                    default: ;
                endcase
            end
            if (adv) begin
                v0_reg <= issue;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (acc && cmd == CMD_MIX && n_next != 4'd0) begin
                        state_reg <= ST_RUN;
                        ch_reg    <= '0;
                        n_reg     <= n_next;
                    end
                end
                ST_RUN: begin
                    if (adv) begin
                        ch_reg <= ch_reg + 3'd1;
                        if ({1'b0, ch_reg} + 4'd1 == n_reg) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
        if (acc && cmd == CMD_MIX) begin
            item_reg.cmds <= s_tdata[63:0];
            item_reg.camt <= s_tdata[84:69];
            item_reg.samt <= s_tdata[103:88];
            item_reg.t_en <= tp.en;
            item_reg.c_en <= (csel != 3'd0) && cp.en;
            item_reg.s_en <= (ssel != 3'd0) && sp.en;
            item_reg.fb   <= tp.fb || ((csel != 3'd0) && cp.fb) || ((ssel != 3'd0) && sp.fb);
            item_reg.ch   <= '0;
            item_reg.last <= 1'b0;
            tidx_reg      <= tp.idx;
            cidx_reg      <= cp.idx;
            sidx_reg      <= sp.idx;
        end
        if (adv) begin
            meta_reg <= meta_next;
        end
    end

    acm_tables u_tables (
        .aclk     (aclk),
        .wr_en    (acc && wr_ok),
        .wr_cmd   (cmd),
        .wr_idx   (widx),
        .wr_data  (wdata),
        .rd_en    (adv),
        .rd_ch    (ch_reg),
        .rd_taddr ({tidx_reg, ch_reg}),
        .rd_caddr ({cidx_reg, ch_reg}),
        .rd_saddr ({sidx_reg, ch_reg}),
        .rd_data  (rd_data)
    );

    acm_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (v0_reg),
        .in_meta     (meta_reg),
        .in_rd       (rd_data),
        .out_floor   (floor_reg),
        .out_ceiling (ceiling_reg),
        .adv         (adv),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );
endmodule
`default_nettype wire
